@@ rtl/core/bpo_pkg.sv @@
// ----------------------------------------------------------------------------
// bpo_pkg
// Shared widths and packed payload types for the bisector offset pipeline.
// ----------------------------------------------------------------------------
package bpo_pkg;

    localparam int COORD_W   = 32;   // coordinate and distance width
    localparam int UNIT_FRAC = 16;   // fraction bits of unit vectors
    localparam int DIFF_W    = 33;   // segment difference width
    localparam int RED_W     = 30;   // magnitude width after range reduction
    localparam int SQ1_K     = 31;   // root bits, first normalisation
    localparam int SQ1_N     = 2 * SQ1_K;
    localparam int NUM1_W    = 47;   // dividend width, first normalisation
    localparam int Q_W       = 17;   // unit component magnitude width
    localparam int SUM_W     = 19;   // signed sum of two unit components
    localparam int SMAG_W    = 18;   // magnitude of that sum
    localparam int SQ2_K     = 18;   // root bits, bisector normalisation
    localparam int SQ2_N     = 2 * SQ2_K;
    localparam int NUM2_W    = 35;   // dividend width, bisector normalisation
    localparam int PROD_W    = 49;   // unit component times distance

    // Fields carried down the whole pipe
    typedef struct packed {
        logic               degen;
        logic               side;
        logic [COORD_W-1:0] p2y;
        logic [COORD_W-1:0] p2x;
    } com_t;

    // One reduced segment direction
    typedef struct packed {
        logic             sy;
        logic             sx;
        logic [RED_W-1:0] ay;
        logic [RED_W-1:0] ax;
    } seg_t;

    // Bisector sum before normalisation
    typedef struct packed {
        logic              sy;
        logic              sx;
        logic [SMAG_W-1:0] ay;
        logic [SMAG_W-1:0] ax;
    } bis_t;

endpackage

@@ rtl/core/bpo_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// bpo_sqrt_cell
// One digit of a restoring integer square root: settles one root bit a cycle while en is high.
// ----------------------------------------------------------------------------
module bpo_sqrt_cell #(
    parameter int K  = 31,   // root bits
    parameter int I  = 0,    // digit handled here, 0 is the top one
    parameter int PW = 1     // side payload width
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            valid_in,
    input  logic [2*K-1:0]  n_in,
    input  logic [K+1:0]    rem_in,
    input  logic [K-1:0]    root_in,
    input  logic [PW-1:0]   pass_in,
    output logic            valid_out,
    output logic [2*K-1:0]  n_out,
    output logic [K+1:0]    rem_out,
    output logic [K-1:0]    root_out,
    output logic [PW-1:0]   pass_out
);

    logic            valid_reg;
    logic [2*K-1:0]  n_reg;
    logic [K+1:0]    rem_reg, rem_next;
    logic [K-1:0]    root_reg, root_next;
    logic [PW-1:0]   pass_reg;
    logic [K+3:0]    cur, trial, diff;
    logic            take;

    // bring down the next two radicand bits and try (4*root + 1)
    always_comb
    begin
        cur       = {rem_in, n_in[2*K-1-2*I -: 2]};
        trial     = (K+4)'({root_in, 2'b01});
        diff      = cur - trial;
        take      = (cur >= trial);
        rem_next  = take ? diff[K+1:0] : cur[K+1:0];
        root_next = {root_in[K-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= n_in;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            pass_reg <= pass_in;
        end
    end

    assign valid_out = valid_reg;
    assign n_out     = n_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign pass_out  = pass_reg;

endmodule

@@ rtl/core/bpo_div_cell.sv @@
// ----------------------------------------------------------------------------
// bpo_div_cell
// One step of a restoring divider: settles one quotient bit a cycle while en is high.
// ----------------------------------------------------------------------------
module bpo_div_cell #(
    parameter int NW = 47,   // dividend / remainder width
    parameter int DW = 31,   // divisor width
    parameter int QW = 17,   // quotient width
    parameter int I  = 16,   // quotient bit settled here
    parameter int PW = 1     // side payload width
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           valid_in,
    input  logic [NW-1:0]  rem_in,
    input  logic [DW-1:0]  den_in,
    input  logic [QW-1:0]  q_in,
    input  logic [PW-1:0]  pass_in,
    output logic           valid_out,
    output logic [NW-1:0]  rem_out,
    output logic [DW-1:0]  den_out,
    output logic [QW-1:0]  q_out,
    output logic [PW-1:0]  pass_out
);

    localparam int CW = (NW > DW + I) ? NW : DW + I;

    logic           valid_reg;
    logic [NW-1:0]  rem_reg, rem_next;
    logic [DW-1:0]  den_reg;
    logic [QW-1:0]  q_reg, q_next;
    logic [PW-1:0]  pass_reg;
    logic [CW-1:0]  r_ext, d_ext, diff;
    logic           ge;

    // compare against the divisor shifted to this bit, subtract on success
    always_comb
    begin
        r_ext    = CW'(rem_in);
        d_ext    = CW'(den_in) << I;
        diff     = r_ext - d_ext;
        ge       = (r_ext >= d_ext);
        rem_next = ge ? NW'(diff) : rem_in;
        q_next   = q_in | (QW'(ge) << I);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            q_reg    <= q_next;
            pass_reg <= pass_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign den_out   = den_reg;
    assign q_out     = q_reg;
    assign pass_out  = pass_reg;

endmodule

@@ rtl/core/polyline_bisector_offset_point.sv @@
// ----------------------------------------------------------------------------
// polyline_bisector_offset_point
// Offsets the middle of three polyline vertices along the bisector normal.
// ----------------------------------------------------------------------------
// Input stream: s_tdata carries the vertices p1, p2, p3, s_tuser the side bit.
// Output stream: m_tdata carries the offset point, m_tuser the flags.
// Config: cfg_we / cfg_wdata load the signed offset distance (8 fraction
// bits); write it only while the pipe is empty.
// From input to output the pipe runs through the difference, range reduction
// and squaring registers, 31 square root cells, 17 divider cells, the bisector
// sum and squaring registers, 18 square root cells, 17 divider cells, the
// multiply register and the output register. Throughput is one item per cycle
// unless the output stalls; every cell holds one item in flight.
// The whole row advances together; it halts only when the output register is
// full and m_tready is low, so s_tready follows m_tready or an empty output.
// A zero-length segment or opposite directions give p2 with degenerate set.
// Reset empties the pipe and clears the offset distance to zero.
// ----------------------------------------------------------------------------
module polyline_bisector_offset_point
    import bpo_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
    input  logic [0:0]   s_tuser,   // side_right
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // offset_x, offset_y
    output logic [1:0]   m_tuser    // degenerate, clipped
);

    localparam int COM_W = $bits(com_t);
    localparam int SEG_W = $bits(seg_t);
    localparam int BIS_W = $bits(bis_t);

    logic en;

    // ------------------------------------------------------------------
    // helpers
    function automatic logic [DIFF_W-1:0] mag_d(input logic [DIFF_W-1:0] v);
        mag_d = v[DIFF_W-1] ? (~v + DIFF_W'(1)) : v;
    endfunction

    function automatic logic [RED_W-1:0] reduce(input logic [DIFF_W-1:0] a,
                                                input logic [1:0] s);
        reduce = RED_W'(a >> s);
    endfunction

    // ------------------------------------------------------------------
    // offset distance register
    logic [COORD_W-1:0] dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dist_reg <= '0;
        else if (cfg_we)
            dist_reg <= cfg_wdata;
    end

    // ------------------------------------------------------------------
    // S0: segment differences
    logic               s0_valid_reg;
    logic [DIFF_W-1:0]  s0_dx1_reg, s0_dy1_reg, s0_dx2_reg, s0_dy2_reg;
    com_t               s0_com_reg;
    logic [COORD_W-1:0] in_x1, in_y1, in_x2, in_y2, in_x3, in_y3;

    assign in_x1 = s_tdata[31:0];
    assign in_y1 = s_tdata[63:32];
    assign in_x2 = s_tdata[95:64];
    assign in_y2 = s_tdata[127:96];
    assign in_x3 = s_tdata[159:128];
    assign in_y3 = s_tdata[191:160];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_dx1_reg       <= {in_x2[31], in_x2} - {in_x1[31], in_x1};
            s0_dy1_reg       <= {in_y2[31], in_y2} - {in_y1[31], in_y1};
            s0_dx2_reg       <= {in_x3[31], in_x3} - {in_x2[31], in_x2};
            s0_dy2_reg       <= {in_y3[31], in_y3} - {in_y2[31], in_y2};
            s0_com_reg.degen <= 1'b0;
            s0_com_reg.side  <= s_tuser[0];
            s0_com_reg.p2x   <= in_x2;
            s0_com_reg.p2y   <= in_y2;
        end
    end

    // ------------------------------------------------------------------
    // S1: magnitudes and range reduction below 2^30
    logic              s1_valid_reg;
    seg_t              s1_v1_reg, s1_v2_reg;
    com_t              s1_com_reg;
    logic [DIFF_W-1:0] ax1, ay1, ax2, ay2, m1, m2;
    logic [1:0]        sh1, sh2;

    always_comb
    begin
        ax1 = mag_d(s0_dx1_reg);
        ay1 = mag_d(s0_dy1_reg);
        ax2 = mag_d(s0_dx2_reg);
        ay2 = mag_d(s0_dy2_reg);
        m1  = (ax1 > ay1) ? ax1 : ay1;
        m2  = (ax2 > ay2) ? ax2 : ay2;
        priority if (m1[32]) sh1 = 2'd3;
        else if (m1[31])     sh1 = 2'd2;
        else if (m1[30])     sh1 = 2'd1;
        else                 sh1 = 2'd0;
        priority if (m2[32]) sh2 = 2'd3;
        else if (m2[31])     sh2 = 2'd2;
        else if (m2[30])     sh2 = 2'd1;
        else                 sh2 = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_v1_reg.ax <= reduce(ax1, sh1);
            s1_v1_reg.ay <= reduce(ay1, sh1);
            s1_v1_reg.sx <= s0_dx1_reg[DIFF_W-1];
            s1_v1_reg.sy <= s0_dy1_reg[DIFF_W-1];
            s1_v2_reg.ax <= reduce(ax2, sh2);
            s1_v2_reg.ay <= reduce(ay2, sh2);
            s1_v2_reg.sx <= s0_dx2_reg[DIFF_W-1];
            s1_v2_reg.sy <= s0_dy2_reg[DIFF_W-1];
            s1_com_reg   <= {(m1 == '0) || (m2 == '0), s0_com_reg.side,
                             s0_com_reg.p2y, s0_com_reg.p2x};
        end
    end

    // ------------------------------------------------------------------
    // S2: squared lengths
    logic             s2_valid_reg;
    logic [SQ1_N-1:0] s2_n1_reg, s2_n2_reg;
    seg_t             s2_v1_reg, s2_v2_reg;
    com_t             s2_com_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_n1_reg  <= SQ1_N'(s1_v1_reg.ax) * SQ1_N'(s1_v1_reg.ax)
                        + SQ1_N'(s1_v1_reg.ay) * SQ1_N'(s1_v1_reg.ay);
            s2_n2_reg  <= SQ1_N'(s1_v2_reg.ax) * SQ1_N'(s1_v2_reg.ax)
                        + SQ1_N'(s1_v2_reg.ay) * SQ1_N'(s1_v2_reg.ay);
            s2_v1_reg  <= s1_v1_reg;
            s2_v2_reg  <= s1_v2_reg;
            s2_com_reg <= s1_com_reg;
        end
    end

    // ------------------------------------------------------------------
    // square root row for both segment lengths
    logic                   r1_valid [0:SQ1_K];
    logic [SQ1_N-1:0]       r1_na    [0:SQ1_K];
    logic [SQ1_N-1:0]       r1_nb    [0:SQ1_K];
    logic [SQ1_K+1:0]       r1_ra    [0:SQ1_K];
    logic [SQ1_K+1:0]       r1_rb    [0:SQ1_K];
    logic [SQ1_K-1:0]       r1_qa    [0:SQ1_K];
    logic [SQ1_K-1:0]       r1_qb    [0:SQ1_K];
    logic [COM_W+SEG_W-1:0] r1_pa    [0:SQ1_K];
    logic [SEG_W-1:0]       r1_pb    [0:SQ1_K];

    assign r1_valid[0] = s2_valid_reg;
    assign r1_na[0]    = s2_n1_reg;
    assign r1_nb[0]    = s2_n2_reg;
    assign r1_ra[0]    = '0;
    assign r1_rb[0]    = '0;
    assign r1_qa[0]    = '0;
    assign r1_qb[0]    = '0;
    assign r1_pa[0]    = {s2_com_reg, s2_v1_reg};
    assign r1_pb[0]    = s2_v2_reg;

    for (genvar i = 0; i < SQ1_K; i++)
    begin : g_sqrt1
        bpo_sqrt_cell #(.K(SQ1_K), .I(i), .PW(COM_W + SEG_W)) u_a (
            .clk(clk), .rst_n(rst_n), .en(en),
            .valid_in(r1_valid[i]), .n_in(r1_na[i]), .rem_in(r1_ra[i]),
            .root_in(r1_qa[i]), .pass_in(r1_pa[i]),
            .valid_out(r1_valid[i+1]), .n_out(r1_na[i+1]), .rem_out(r1_ra[i+1]),
            .root_out(r1_qa[i+1]), .pass_out(r1_pa[i+1])
        );
        bpo_sqrt_cell #(.K(SQ1_K), .I(i), .PW(SEG_W)) u_b (
            .clk(clk), .rst_n(rst_n), .en(en),
            .valid_in(r1_valid[i]), .n_in(r1_nb[i]), .rem_in(r1_rb[i]),
            .root_in(r1_qb[i]), .pass_in(r1_pb[i]),
            .valid_out(), .n_out(r1_nb[i+1]), .rem_out(r1_rb[i+1]),
            .root_out(r1_qb[i+1]), .pass_out(r1_pb[i+1])
        );
    end

    // ------------------------------------------------------------------
    // divider row: four components over their lengths, rounded
    com_t              r1_com;
    seg_t              r1_v1, r1_v2;
    logic [SQ1_K-1:0]  len1, len2;

    assign r1_com = com_t'(r1_pa[SQ1_K][COM_W+SEG_W-1:SEG_W]);
    assign r1_v1  = seg_t'(r1_pa[SQ1_K][SEG_W-1:0]);
    assign r1_v2  = seg_t'(r1_pb[SQ1_K]);
    assign len1   = r1_qa[SQ1_K];
    assign len2   = r1_qb[SQ1_K];

    logic              d1_valid [0:Q_W];
    logic [NUM1_W-1:0] d1_r     [0:3][0:Q_W];
    logic [SQ1_K-1:0]  d1_d     [0:3][0:Q_W];
    logic [Q_W-1:0]    d1_q     [0:3][0:Q_W];
    logic [COM_W:0]    d1_p0    [0:Q_W];
    logic              d1_ps    [1:3][0:Q_W];

    assign d1_valid[0] = r1_valid[SQ1_K];
    assign d1_r[0][0]  = (NUM1_W'(r1_v1.ax) << UNIT_FRAC) + NUM1_W'(len1 >> 1);
    assign d1_r[1][0]  = (NUM1_W'(r1_v1.ay) << UNIT_FRAC) + NUM1_W'(len1 >> 1);
    assign d1_r[2][0]  = (NUM1_W'(r1_v2.ax) << UNIT_FRAC) + NUM1_W'(len2 >> 1);
    assign d1_r[3][0]  = (NUM1_W'(r1_v2.ay) << UNIT_FRAC) + NUM1_W'(len2 >> 1);
    assign d1_d[0][0]  = len1;
    assign d1_d[1][0]  = len1;
    assign d1_d[2][0]  = len2;
    assign d1_d[3][0]  = len2;
    assign d1_q[0][0]  = '0;
    assign d1_q[1][0]  = '0;
    assign d1_q[2][0]  = '0;
    assign d1_q[3][0]  = '0;
    assign d1_p0[0]    = {r1_com, r1_v1.sx};
    assign d1_ps[1][0] = r1_v1.sy;
    assign d1_ps[2][0] = r1_v2.sx;
    assign d1_ps[3][0] = r1_v2.sy;

    for (genvar i = 0; i < Q_W; i++)
    begin : g_div1
        bpo_div_cell #(.NW(NUM1_W), .DW(SQ1_K), .QW(Q_W), .I(Q_W-1-i),
                       .PW(COM_W + 1)) u_0 (
            .clk(clk), .rst_n(rst_n), .en(en),
            .valid_in(d1_valid[i]), .rem_in(d1_r[0][i]), .den_in(d1_d[0][i]),
            .q_in(d1_q[0][i]), .pass_in(d1_p0[i]),
            .valid_out(d1_valid[i+1]), .rem_out(d1_r[0][i+1]),
            .den_out(d1_d[0][i+1]), .q_out(d1_q[0][i+1]), .pass_out(d1_p0[i+1])
        );
        for (genvar c = 1; c < 4; c++)
        begin : g_comp
            bpo_div_cell #(.NW(NUM1_W), .DW(SQ1_K), .QW(Q_W), .I(Q_W-1-i),
                           .PW(1)) u_c (
                .clk(clk), .rst_n(rst_n), .en(en),
                .valid_in(d1_valid[i]), .rem_in(d1_r[c][i]), .den_in(d1_d[c][i]),
                .q_in(d1_q[c][i]), .pass_in(d1_ps[c][i]),
                .valid_out(), .rem_out(d1_r[c][i+1]),
                .den_out(d1_d[c][i+1]), .q_out(d1_q[c][i+1]),
                .pass_out(d1_ps[c][i+1])
            );
        end
    end

    // ------------------------------------------------------------------
    // S3: sum of the unit directions
    com_t             d1_com;
    logic [SUM_W-1:0] ux1, uy1, ux2, uy2, bsx, bsy;
    logic             s3_valid_reg;
    bis_t             s3_b_reg;
    com_t             s3_com_reg;

    always_comb
    begin
        d1_com = com_t'(d1_p0[Q_W][COM_W:1]);
        ux1 = d1_p0[Q_W][0] ? -SUM_W'(d1_q[0][Q_W]) : SUM_W'(d1_q[0][Q_W]);
        uy1 = d1_ps[1][Q_W] ? -SUM_W'(d1_q[1][Q_W]) : SUM_W'(d1_q[1][Q_W]);
        ux2 = d1_ps[2][Q_W] ? -SUM_W'(d1_q[2][Q_W]) : SUM_W'(d1_q[2][Q_W]);
        uy2 = d1_ps[3][Q_W] ? -SUM_W'(d1_q[3][Q_W]) : SUM_W'(d1_q[3][Q_W]);
        bsx = ux1 + ux2;
        bsy = uy1 + uy2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= d1_valid[Q_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_b_reg.sx <= bsx[SUM_W-1];
            s3_b_reg.sy <= bsy[SUM_W-1];
            s3_b_reg.ax <= SMAG_W'(bsx[SUM_W-1] ? -bsx : bsx);
            s3_b_reg.ay <= SMAG_W'(bsy[SUM_W-1] ? -bsy : bsy);
            s3_com_reg  <= {d1_com.degen || ((bsx == '0) && (bsy == '0)),
                            d1_com.side, d1_com.p2y, d1_com.p2x};
        end
    end

    // ------------------------------------------------------------------
    // S4: squared bisector length
    logic             s4_valid_reg;
    logic [SQ2_N-1:0] s4_n_reg;
    bis_t             s4_b_reg;
    com_t             s4_com_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (en)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_n_reg   <= SQ2_N'(s3_b_reg.ax) * SQ2_N'(s3_b_reg.ax)
                        + SQ2_N'(s3_b_reg.ay) * SQ2_N'(s3_b_reg.ay);
            s4_b_reg   <= s3_b_reg;
            s4_com_reg <= s3_com_reg;
        end
    end

    // ------------------------------------------------------------------
    // square root row for the bisector length
    logic                   r2_valid [0:SQ2_K];
    logic [SQ2_N-1:0]       r2_n     [0:SQ2_K];
    logic [SQ2_K+1:0]       r2_r     [0:SQ2_K];
    logic [SQ2_K-1:0]       r2_q     [0:SQ2_K];
    logic [COM_W+BIS_W-1:0] r2_p     [0:SQ2_K];

    assign r2_valid[0] = s4_valid_reg;
    assign r2_n[0]     = s4_n_reg;
    assign r2_r[0]     = '0;
    assign r2_q[0]     = '0;
    assign r2_p[0]     = {s4_com_reg, s4_b_reg};

    for (genvar i = 0; i < SQ2_K; i++)
    begin : g_sqrt2
        bpo_sqrt_cell #(.K(SQ2_K), .I(i), .PW(COM_W + BIS_W)) u_s (
            .clk(clk), .rst_n(rst_n), .en(en),
            .valid_in(r2_valid[i]), .n_in(r2_n[i]), .rem_in(r2_r[i]),
            .root_in(r2_q[i]), .pass_in(r2_p[i]),
            .valid_out(r2_valid[i+1]), .n_out(r2_n[i+1]), .rem_out(r2_r[i+1]),
            .root_out(r2_q[i+1]), .pass_out(r2_p[i+1])
        );
    end

    // ------------------------------------------------------------------
    // divider row for the unit bisector
    com_t             r2_com;
    bis_t             r2_b;
    logic [SQ2_K-1:0] len3;

    assign r2_com = com_t'(r2_p[SQ2_K][COM_W+BIS_W-1:BIS_W]);
    assign r2_b   = bis_t'(r2_p[SQ2_K][BIS_W-1:0]);
    assign len3   = r2_q[SQ2_K];

    logic              d2_valid [0:Q_W];
    logic [NUM2_W-1:0] d2_r     [0:1][0:Q_W];
    logic [SQ2_K-1:0]  d2_d     [0:1][0:Q_W];
    logic [Q_W-1:0]    d2_q     [0:1][0:Q_W];
    logic [COM_W:0]    d2_px    [0:Q_W];
    logic              d2_py    [0:Q_W];

    assign d2_valid[0] = r2_valid[SQ2_K];
    assign d2_r[0][0]  = (NUM2_W'(r2_b.ax) << UNIT_FRAC) + NUM2_W'(len3 >> 1);
    assign d2_r[1][0]  = (NUM2_W'(r2_b.ay) << UNIT_FRAC) + NUM2_W'(len3 >> 1);
    assign d2_d[0][0]  = len3;
    assign d2_d[1][0]  = len3;
    assign d2_q[0][0]  = '0;
    assign d2_q[1][0]  = '0;
    assign d2_px[0]    = {r2_com, r2_b.sx};
    assign d2_py[0]    = r2_b.sy;

    for (genvar i = 0; i < Q_W; i++)
    begin : g_div2
        bpo_div_cell #(.NW(NUM2_W), .DW(SQ2_K), .QW(Q_W), .I(Q_W-1-i),
                       .PW(COM_W + 1)) u_x (
            .clk(clk), .rst_n(rst_n), .en(en),
            .valid_in(d2_valid[i]), .rem_in(d2_r[0][i]), .den_in(d2_d[0][i]),
            .q_in(d2_q[0][i]), .pass_in(d2_px[i]),
            .valid_out(d2_valid[i+1]), .rem_out(d2_r[0][i+1]),
            .den_out(d2_d[0][i+1]), .q_out(d2_q[0][i+1]), .pass_out(d2_px[i+1])
        );
        bpo_div_cell #(.NW(NUM2_W), .DW(SQ2_K), .QW(Q_W), .I(Q_W-1-i),
                       .PW(1)) u_y (
            .clk(clk), .rst_n(rst_n), .en(en),
            .valid_in(d2_valid[i]), .rem_in(d2_r[1][i]), .den_in(d2_d[1][i]),
            .q_in(d2_q[1][i]), .pass_in(d2_py[i]),
            .valid_out(), .rem_out(d2_r[1][i+1]),
            .den_out(d2_d[1][i+1]), .q_out(d2_q[1][i+1]), .pass_out(d2_py[i+1])
        );
    end

    // ------------------------------------------------------------------
    // S5: rotate and scale by the distance (magnitudes, sign kept aside)
    com_t               d2_com;
    logic               bsx_neg, bsy_neg, d_neg;
    logic [COORD_W-1:0] dmag;
    logic               s5_valid_reg;
    logic [PROD_W-1:0]  s5_px_reg, s5_py_reg;
    logic               s5_nx_reg, s5_ny_reg;
    com_t               s5_com_reg;

    always_comb
    begin
        d2_com  = com_t'(d2_px[Q_W][COM_W:1]);
        bsx_neg = d2_px[Q_W][0];
        bsy_neg = d2_py[Q_W];
        d_neg   = dist_reg[COORD_W-1];
        dmag    = d_neg ? -dist_reg : dist_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (en)
            s5_valid_reg <= d2_valid[Q_W];
    end

    // right: n = (by, -bx); left: n = (-by, bx)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_px_reg  <= PROD_W'(d2_q[1][Q_W]) * PROD_W'(dmag);
            s5_py_reg  <= PROD_W'(d2_q[0][Q_W]) * PROD_W'(dmag);
            s5_nx_reg  <= (d2_com.side ? bsy_neg : !bsy_neg) ^ d_neg;
            s5_ny_reg  <= (d2_com.side ? !bsx_neg : bsx_neg) ^ d_neg;
            s5_com_reg <= d2_com;
        end
    end

    // ------------------------------------------------------------------
    // S6: round, add to p2, saturate; output register
    localparam int RQ_W  = PROD_W - UNIT_FRAC;   // rounded magnitude
    localparam int ACC_W = RQ_W + 2;

    logic [PROD_W-1:0]  rpx, rpy;
    logic [ACC_W-1:0]   ox, oy, sx_acc, sy_acc;
    logic [COORD_W-1:0] sat_x, sat_y;
    logic               clip_x, clip_y;

    function automatic logic [COORD_W-1:0] sat(input logic [ACC_W-1:0] v,
                                               output logic clip);
        logic [ACC_W-1:0] hi, lo;
        hi = ACC_W'({1'b0, {(COORD_W-1){1'b1}}});
        lo = ~hi;
        clip = 1'b0;
        sat  = COORD_W'(v);
        if ($signed(v) > $signed(hi))
        begin
            clip = 1'b1;
            sat  = COORD_W'(hi);
        end
        else if ($signed(v) < $signed(lo))
        begin
            clip = 1'b1;
            sat  = COORD_W'(lo);
        end
    endfunction

    always_comb
    begin
        rpx    = s5_px_reg + PROD_W'(1 << (UNIT_FRAC - 1));
        rpy    = s5_py_reg + PROD_W'(1 << (UNIT_FRAC - 1));
        ox     = ACC_W'(rpx[PROD_W-1:UNIT_FRAC]);
        oy     = ACC_W'(rpy[PROD_W-1:UNIT_FRAC]);
        if (s5_nx_reg)
            ox = -ox;
        if (s5_ny_reg)
            oy = -oy;
        sx_acc = ACC_W'($signed(s5_com_reg.p2x)) + ox;
        sy_acc = ACC_W'($signed(s5_com_reg.p2y)) + oy;
        sat_x  = sat(sx_acc, clip_x);
        sat_y  = sat(sy_acc, clip_y);
    end

    logic               out_valid_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    logic               out_degen_reg, out_clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_degen_reg <= s5_com_reg.degen;
            if (s5_com_reg.degen)
            begin
                out_x_reg    <= s5_com_reg.p2x;
                out_y_reg    <= s5_com_reg.p2y;
                out_clip_reg <= 1'b0;
            end
            else
            begin
                out_x_reg    <= sat_x;
                out_y_reg    <= sat_y;
                out_clip_reg <= clip_x || clip_y;
            end
        end
    end

    // the row moves whenever the output register is free or being taken
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};
    assign m_tuser  = {out_clip_reg, out_degen_reg};

    // ------------------------------------------------------------------
    // checks
    a_degen_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("degenerate result reported as clipped");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(s5_valid_reg) && $stable(s5_px_reg))
        else $error("pipe moved during output stall");

endmodule

@@ tb/polyline_bisector_offset_point_tb.sv @@
// ----------------------------------------------------------------------------
// polyline_bisector_offset_point_tb
// Self-checking bench for the bisector offset block. Vertex triples are
// streamed in with random gaps while the result side stalls at random. A
// scoreboard predicts each offset point in 64-bit integer arithmetic and
// compares every field of every result in order. The offset distance is
// reloaded between phases once the pipe has drained.
// ----------------------------------------------------------------------------
module polyline_bisector_offset_point_tb;
    import bpo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic        degen;
        logic        clip;
    } offset_res_t;

    // ------------------------------------------------------------------------
    // Predicts offset points and checks results against them in order
    // ------------------------------------------------------------------------
    class offset_scoreboard;
        offset_res_t pending[$];
        longint      offset_dist;
        int          errors;
        int          n_checked;
        int          n_degen;
        int          n_clip;

        function new();
            offset_dist = 0;
            errors = 0;
            n_checked = 0;
            n_degen = 0;
            n_clip = 0;
        endfunction

        function longint unsigned absval(longint v);
            return (v < 0) ? longint'(-v) : longint'(v);
        endfunction

        function longint unsigned int_root(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n)
                b = b >> 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // Unit direction with UNIT_FRAC fraction bits; 0 when length is zero
        function bit unit_dir(longint x, longint y, output longint ux, output longint uy);
            longint unsigned ax;
            longint unsigned ay;
            longint unsigned m;
            longint unsigned len;
            longint unsigned qx;
            longint unsigned qy;
            ax = absval(x);
            ay = absval(y);
            ux = 0;
            uy = 0;
            m = (ax > ay) ? ax : ay;
            if (m == 0)
                return 0;
            while (m >= (64'd1 << 30))
            begin
                m = m >> 1;
                ax = ax >> 1;
                ay = ay >> 1;
            end
            len = int_root(ax * ax + ay * ay);
            if (len == 0)
                return 0;
            qx = ((ax << UNIT_FRAC) + (len >> 1)) / len;
            qy = ((ay << UNIT_FRAC) + (len >> 1)) / len;
            ux = (x < 0) ? -longint'(qx) : longint'(qx);
            uy = (y < 0) ? -longint'(qy) : longint'(qy);
            return 1;
        endfunction

        // Round to nearest, ties away from zero
        function longint scaled(longint n, longint d);
            longint unsigned q;
            q = (absval(n) * absval(d) + (64'd1 << (UNIT_FRAC - 1))) >> UNIT_FRAC;
            return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
        endfunction

        function longint clamp(longint v, inout bit clip);
            if (v > 64'sd2147483647)
            begin
                clip = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                clip = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function void note_item(logic [191:0] data, logic side);
            longint x1, y1, x2, y2, x3, y3;
            longint u1x, u1y, u2x, u2y, bx, by, nx, ny, rx, ry;
            bit clip;
            bit degen;
            offset_res_t r;
            x1 = longint'($signed(data[31:0]));
            y1 = longint'($signed(data[63:32]));
            x2 = longint'($signed(data[95:64]));
            y2 = longint'($signed(data[127:96]));
            x3 = longint'($signed(data[159:128]));
            y3 = longint'($signed(data[191:160]));
            rx = x2;
            ry = y2;
            clip = 0;
            degen = 1;
            if (unit_dir(x2 - x1, y2 - y1, u1x, u1y) &&
                unit_dir(x3 - x2, y3 - y2, u2x, u2y) &&
                unit_dir(u1x + u2x, u1y + u2y, bx, by))
            begin
                nx = side ? by : -by;
                ny = side ? -bx : bx;
                degen = 0;
                rx = clamp(x2 + scaled(nx, offset_dist), clip);
                ry = clamp(y2 + scaled(ny, offset_dist), clip);
            end
            r.x = rx[31:0];
            r.y = ry[31:0];
            r.degen = degen;
            r.clip = clip;
            pending.push_back(r);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch on result %0d: %s got %h expected %h",
                     n_checked, what, got, want);
        endtask

        task check_result(logic [63:0] data, logic [1:0] flags);
            offset_res_t e;
            if (pending.size() == 0)
            begin
                errors++;
                $display("result with no item outstanding: %h %b", data, flags);
                return;
            end
            e = pending.pop_front();
            if (data[31:0] !== e.x)
                report_mismatch("offset_x", data[31:0], e.x);
            if (data[63:32] !== e.y)
                report_mismatch("offset_y", data[63:32], e.y);
            if (flags[0] !== e.degen)
                report_mismatch("degenerate", flags[0], e.degen);
            if (flags[1] !== e.clip)
                report_mismatch("clipped", flags[1], e.clip);
            n_degen += e.degen;
            n_clip += e.clip;
            n_checked++;
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;      // p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
    logic [0:0]   s_tuser;      // side_right
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;      // offset_x, offset_y
    logic [1:0]   m_tuser;      // degenerate, clipped

    offset_scoreboard sb;
    int               cycles;
    int               n_sent;

    polyline_bisector_offset_point i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, runs of none
    function int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 5);
    endfunction

    // Result side back-pressure; bursts of always-ready in between
    int stall_left;
    int ready_run;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left <= 0;
            ready_run <= 0;
        end
        else if (ready_run > 0)
        begin
            m_tready <= 1'b1;
            ready_run <= ready_run - 1;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(19) == 0)
        begin
            m_tready <= 1'b1;
            ready_run <= $urandom_range(200, 20);
        end
        else
        begin
            m_tready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Monitors on both streams
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_item(s_tdata, s_tuser[0]);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", sb.pending.size());
            $display("polyline_bisector_offset_point_tb failed");
            $finish;
        end
    end

    // Push one vertex triple, holding tvalid high across back-to-back items
    task send_triple(logic [31:0] x1, logic [31:0] y1, logic [31:0] x2,
                     logic [31:0] y2, logic [31:0] x3, logic [31:0] y3, logic side);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y3, x3, y2, x2, y1, x1};
        s_tuser <= side;
        do
            @(posedge clk);
        while (!s_tready);
        n_sent++;
    endtask

    // Drain the pipe, then load a new distance
    task load_distance(logic [31:0] d);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= d;
        @(posedge clk);
        sb.offset_dist = longint'($signed(d));
        cfg_we <= 1'b0;
    endtask

    // Random triple: mostly nearby vertices of a polyline, some noise
    task send_random();
        logic [31:0] x1, y1, x2, y2, x3, y3;
        int sh;
        int mode;
        mode = $urandom_range(99);
        sh = $urandom_range(24, 1);
        x2 = $urandom;
        y2 = $urandom;
        x1 = x2 + ($urandom_range(1) ? 32'($urandom) >> (32 - sh) : -(32'($urandom) >> (32 - sh)));
        y1 = y2 + ($urandom_range(1) ? 32'($urandom) >> (32 - sh) : -(32'($urandom) >> (32 - sh)));
        x3 = x2 + ($urandom_range(1) ? 32'($urandom) >> (32 - sh) : -(32'($urandom) >> (32 - sh)));
        y3 = y2 + ($urandom_range(1) ? 32'($urandom) >> (32 - sh) : -(32'($urandom) >> (32 - sh)));
        if (mode < 20)
        begin
            x1 = $urandom;
            y1 = $urandom;
            x3 = $urandom;
            y3 = $urandom;
        end
        else if (mode < 25)
        begin
            x1 = x2;
            y1 = y2;
        end
        else if (mode < 30)
        begin
            x3 = x2;
            y3 = y2;
        end
        else if (mode < 35)
        begin
            // straight back along the same segment
            x3 = x1;
            y3 = y1;
        end
        else if (mode < 42)
        begin
            // p2 near the coordinate limits
            x2 = $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(4000) :
                                     32'h8000_0000 + $urandom_range(4000);
            y2 = $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(4000) :
                                     32'h8000_0000 + $urandom_range(4000);
            x1 = x2 - $urandom_range(2000);
            y1 = y2 + $urandom_range(2000);
            x3 = x2 + $urandom_range(2000);
            y3 = y2 - $urandom_range(2000);
        end
        send_triple(x1, y1, x2, y2, x3, y3, $urandom_range(1));
    endtask

    // Directed corners
    task send_directed();
        logic [31:0] mx;
        logic [31:0] mn;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;
        // right angle, both sides
        send_triple(0, 0, 32'd2560, 0, 32'd2560, 32'd2560, 0);
        send_triple(0, 0, 32'd2560, 0, 32'd2560, 32'd2560, 1);
        // collinear
        send_triple(0, 0, 32'd256, 32'd256, 32'd512, 32'd512, 0);
        // first segment zero length
        send_triple(32'd100, 32'd200, 32'd100, 32'd200, 32'd900, 32'd5, 0);
        // second segment zero length
        send_triple(32'd7, 32'd9, 32'd100, 32'd200, 32'd100, 32'd200, 1);
        // all three equal
        send_triple(mn, mx, mn, mx, mn, mx, 1);
        // reversal: directions sum to zero
        send_triple(0, 0, 32'd512, 0, 0, 0, 0);
        send_triple(32'd300, 32'd400, 0, 0, 32'd300, 32'd400, 1);
        // extreme spans that need range reduction
        send_triple(mn, mn, mx, mx, mn, mx, 0);
        send_triple(mx, mn, mn, mx, mx, mx, 1);
        send_triple(mn, 0, mx, 0, mx, mn, 0);
        // p2 at the limits so the offset can saturate
        send_triple(mx - 32'd10, mx - 32'd10, mx, mx, mx, mx - 32'd10, 0);
        send_triple(mx - 32'd10, mx - 32'd10, mx, mx, mx, mx - 32'd10, 1);
        send_triple(mn + 32'd10, mn + 32'd10, mn, mn, mn, mn + 32'd10, 0);
        send_triple(mn + 32'd10, mn + 32'd10, mn, mn, mn, mn + 32'd10, 1);
        // unit steps
        send_triple(32'hffff_ffff, 0, 0, 0, 0, 32'd1, 0);
        send_triple(0, 32'd1, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 1);
        // all-ones and alternating patterns
        send_triple(32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff, 0,
                    32'h5555_5555, 32'haaaa_aaaa, 1);
    endtask

    logic [31:0] dist_set [7];

    initial
    begin
        sb = new();
        clk = 1'b0;
        cycles = 0;
        n_sent = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        dist_set[0] = 32'd2560;
        dist_set[1] = 32'h7fff_ffff;
        dist_set[2] = 32'h8000_0000;
        dist_set[3] = 32'hffff_fd00;
        dist_set[4] = 32'd0;
        dist_set[5] = 32'd1;
        dist_set[6] = $urandom;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default distance after reset, before any write
        send_directed();
        for (int ph = 0; ph < 7; ph++)
        begin
            load_distance(dist_set[ph]);
            if (ph == 0 || ph == 2)
                send_directed();
            for (int k = 0; k < 200; k++)
                send_random();
        end
        s_tvalid <= 1'b0;

        // Wait for the tail of the pipe
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d triples sent over 8 distance settings, %0d results checked",
                 n_sent, sb.n_checked);
        $display("%0d degenerate, %0d saturated, %0d mismatches",
                 sb.n_degen, sb.n_clip, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("polyline_bisector_offset_point_tb passed");
        else
            $display("polyline_bisector_offset_point_tb failed");
        $finish;
    end

endmodule
